// ===== hdl/zone_bitmap_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// zone bitmap allocator assertion macros
// concurrent checks on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef ZONE_BITMAP_ALLOCATOR_DEFINES_SVH
`define ZONE_BITMAP_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define ZBA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ZBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ZBA_ASSERT_IMPLY(lbl, ante, cons, msg)
`define ZBA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/zba_pkg.sv =====
// ----------------------------------------------------------------------------
// zba_pkg
// shared types, sizes and codes of the zone bitmap allocator
// ----------------------------------------------------------------------------
package zba_pkg;

    // map geometry
    localparam int MAP_BITS       = 4096;
    localparam int WORD_BITS      = 64;
    localparam int BIT_W          = $clog2(WORD_BITS);
    localparam int MAP_BYTES      = MAP_BITS / 8;
    localparam int MAP_WORDS      = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int MAP_AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int MAP_OFF_W      = $clog2(MAP_BITS);
    localparam int SCAN_W         = $clog2(MAP_BYTES + 1);
    localparam int WCNT_W         = $clog2(MAP_WORDS + 1);
    localparam int HIT_W          = MAP_AW + BIT_W;

    // field widths
    localparam int BLK_W          = 16;
    localparam int ZC_W           = 13;
    localparam int STATUS_W       = 3;
    localparam int CFG_DATA_W     = 16;

    // register indexes
    localparam logic CFG_FIRST_DATA_ZONE = 1'b0;
    localparam logic CFG_ZONE_COUNT      = 1'b1;
    localparam logic [ZC_W-1:0] ZONE_COUNT_RESET = 13'd4096;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NONE_FREE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BEYOND       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd4;

    typedef struct packed {
        logic             cmd;
        logic [BLK_W-1:0] block_number;
    } t_cmd_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BLK_W-1:0]    block_number_out;
    } t_result;

    typedef struct packed {
        logic [BLK_W-1:0] first_data_zone;
        logic [ZC_W-1:0]  zone_count;
    } t_cfg;

    // classified job kinds
    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_RANGE
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [MAP_OFF_W-1:0] off;
        logic [SCAN_W-1:0]    scan_bytes;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== hdl/zba_ram.sv =====
// ----------------------------------------------------------------------------
// zba_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module zba_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/zba_front.sv =====
// ----------------------------------------------------------------------------
// zba_front
// configuration registers, command acceptance and classification
// ----------------------------------------------------------------------------
module zba_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  zba_pkg::t_cmd_in              i_cmd,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [zba_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  zba_pkg::t_q_stat              i_q_stat,
    output logic                          o_busy,
    output logic                          o_push,
    output zba_pkg::t_job                 o_job,
    output zba_pkg::t_cfg                 o_cfg
);

    localparam int EXT_W = 17;

    zba_pkg::t_cfg r_cfg;

    logic [EXT_W-1:0]         w_lim;
    logic [zba_pkg::BLK_W-1:0] w_off16;
    logic                     w_in_range;
    logic [EXT_W-1:0]         w_span;
    logic [EXT_W-1:0]         w_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_data_zone <= '0;
            r_cfg.zone_count      <= zba_pkg::ZONE_COUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                zba_pkg::CFG_FIRST_DATA_ZONE: begin
                    r_cfg.first_data_zone <= i_cfg_data;
                end
                zba_pkg::CFG_ZONE_COUNT: begin
                    r_cfg.zone_count <= i_cfg_data[zba_pkg::ZC_W-1:0];
                end
            endcase
        end
    end

    // free range check
    always_comb begin
        w_lim      = EXT_W'(r_cfg.first_data_zone) + EXT_W'(r_cfg.zone_count);
        w_off16    = i_cmd.block_number - r_cfg.first_data_zone;
        w_in_range = (i_cmd.block_number >= r_cfg.first_data_zone)
                  && (EXT_W'(i_cmd.block_number) < w_lim)
                  && (EXT_W'(w_off16) < EXT_W'(zba_pkg::MAP_BITS));
    end

    // allocate scan length in bytes
    always_comb begin
        w_span  = EXT_W'(r_cfg.zone_count) - EXT_W'(r_cfg.first_data_zone) + EXT_W'(1);
        w_bytes = (w_span + EXT_W'(7)) >> 3;
        o_job.scan_bytes = '0;
        if (EXT_W'(r_cfg.first_data_zone) > EXT_W'(r_cfg.zone_count)) begin
            o_job.scan_bytes = '0;
        end else if (w_bytes > EXT_W'(zba_pkg::MAP_BYTES)) begin
            o_job.scan_bytes = zba_pkg::SCAN_W'(zba_pkg::MAP_BYTES);
        end else begin
            o_job.scan_bytes = zba_pkg::SCAN_W'(w_bytes);
        end
        o_job.off = zba_pkg::MAP_OFF_W'(w_off16);
        if (i_cmd.cmd == zba_pkg::CMD_FREE) begin
            o_job.op = w_in_range ? zba_pkg::OP_FREE : zba_pkg::OP_RANGE;
        end else begin
            o_job.op = zba_pkg::OP_ALLOC;
        end
    end

    assign o_busy = i_q_stat.full;
    assign o_push = i_start && !i_q_stat.full;
    assign o_cfg  = r_cfg;

endmodule

// ===== hdl/zba_queue.sv =====
// ----------------------------------------------------------------------------
// zba_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
`include "zone_bitmap_allocator_defines.svh"

module zba_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  zba_pkg::t_job     i_job,
    input  logic              i_pop,
    output zba_pkg::t_job     o_job,
    output zba_pkg::t_q_stat  o_stat
);

    localparam int DEPTH = 2;

    zba_pkg::t_job r_mem [DEPTH];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_job        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == 2'(DEPTH));
    assign o_stat.empty = (r_count == 2'd0);

    `ZBA_ASSERT_NEXT(a_push_not_empty, i_push && !i_pop, !o_stat.empty, "queue empty after push")

endmodule

// ===== hdl/zba_back.sv =====
// ----------------------------------------------------------------------------
// zba_back
// bitmap engine: word scan for allocate, read-modify-write for free
// ----------------------------------------------------------------------------
`include "zone_bitmap_allocator_defines.svh"

module zba_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  zba_pkg::t_cfg     i_cfg,
    input  zba_pkg::t_q_stat  i_q_stat,
    input  zba_pkg::t_job     i_job,
    output logic              o_pop,
    output logic              o_res_valid,
    output zba_pkg::t_result  o_res
);

    localparam int BIDX_W = zba_pkg::MAP_AW + 3;
    localparam int CMP_W  = (BIDX_W > zba_pkg::SCAN_W) ? BIDX_W + 1 : zba_pkg::SCAN_W + 1;
    localparam int SW1    = zba_pkg::SCAN_W + 4;
    localparam int EXT_W  = 17;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FOUND,
        S_FREE_CHK
    } t_state;

    t_state                          r_state,     n_state;
    zba_pkg::t_job                   r_job,       n_job;
    logic [zba_pkg::WCNT_W-1:0]      r_words,     n_words;
    logic [zba_pkg::WCNT_W-1:0]      r_issue,     n_issue;
    logic                            r_chk_v,     n_chk_v;
    logic [zba_pkg::MAP_AW-1:0]      r_chk_w,     n_chk_w;
    logic [zba_pkg::HIT_W-1:0]       r_hit_off,   n_hit_off;
    logic [zba_pkg::WORD_BITS-1:0]   r_hit_word,  n_hit_word;
    logic [zba_pkg::MAP_WORDS-1:0]   r_valid,     n_valid;
    logic                            r_res_valid, n_res_valid;
    zba_pkg::t_result                r_res,       n_res;

    logic                            w_ram_we;
    logic [zba_pkg::MAP_AW-1:0]      w_ram_waddr;
    logic [zba_pkg::WORD_BITS-1:0]   w_ram_wdata;
    logic [zba_pkg::MAP_AW-1:0]      w_ram_raddr;
    logic [zba_pkg::WORD_BITS-1:0]   w_ram_rdata;

    logic [zba_pkg::WORD_BITS-1:0]   w_eff;
    logic [7:0]                      w_cand;
    logic                            w_any;
    logic [2:0]                      w_sel_b;
    logic [7:0]                      w_sel_byte;
    logic [2:0]                      w_sel_j;
    logic [zba_pkg::BIT_W-1:0]       w_hit_bit;
    logic [zba_pkg::BIT_W-1:0]       w_free_bit;
    logic [zba_pkg::MAP_AW-1:0]      w_free_w;

    zba_ram #(
        .WIDTH (zba_pkg::WORD_BITS),
        .DEPTH (zba_pkg::MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // word in the read register, never-written rows read as clear
    always_comb begin
        w_free_w   = zba_pkg::MAP_AW'(r_job.off >> zba_pkg::BIT_W);
        w_free_bit = zba_pkg::BIT_W'(r_job.off);
        if (r_state == S_FREE_CHK) begin
            w_eff = r_valid[w_free_w] ? w_ram_rdata : '0;
        end else begin
            w_eff = r_valid[r_chk_w] ? w_ram_rdata : '0;
        end
    end

    // first non-full byte inside the scan limit, then first clear bit in it
    always_comb begin
        w_sel_b = '0;
        w_sel_j = '0;
        for (int b = 0; b < 8; b++) begin
            w_cand[b] = (CMP_W'({r_chk_w, 3'(b)}) < CMP_W'(r_job.scan_bytes))
                     && (w_eff[b*8 +: 8] != 8'hFF);
        end
        w_any = |w_cand;
        for (int b = 7; b >= 0; b--) begin
            if (w_cand[b]) begin
                w_sel_b = 3'(b);
            end
        end
        w_sel_byte = w_eff[w_sel_b*8 +: 8];
        for (int j = 7; j >= 0; j--) begin
            if (!w_sel_byte[j]) begin
                w_sel_j = 3'(j);
            end
        end
        w_hit_bit = {w_sel_b, w_sel_j};
    end

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_words     = r_words;
        n_issue     = r_issue;
        n_chk_v     = 1'b0;
        n_chk_w     = r_chk_w;
        n_hit_off   = r_hit_off;
        n_hit_word  = r_hit_word;
        n_valid     = r_valid;
        n_res_valid = 1'b0;
        n_res       = r_res;
        o_pop       = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_waddr = w_free_w;
        w_ram_wdata = w_eff;
        w_ram_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                    unique case (i_job.op)
                        zba_pkg::OP_ALLOC: begin
                            n_words = zba_pkg::WCNT_W'((SW1'(i_job.scan_bytes) + SW1'(7)) >> 3);
                            if (i_job.scan_bytes == '0) begin
                                n_res_valid = 1'b1;
                                n_res.status = zba_pkg::ST_NONE_FREE;
                                n_res.block_number_out = '0;
                            end else begin
                                w_ram_raddr = '0;
                                n_issue     = zba_pkg::WCNT_W'(1);
                                n_chk_v     = 1'b1;
                                n_chk_w     = '0;
                                n_state     = S_SCAN;
                            end
                        end
                        zba_pkg::OP_FREE: begin
                            w_ram_raddr = zba_pkg::MAP_AW'(i_job.off >> zba_pkg::BIT_W);
                            n_state     = S_FREE_CHK;
                        end
                        default: begin
                            n_res_valid = 1'b1;
                            n_res.status = zba_pkg::ST_RANGE;
                            n_res.block_number_out = '0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // keep one read in flight ahead of the check
                if (r_issue < r_words) begin
                    w_ram_raddr = r_issue[zba_pkg::MAP_AW-1:0];
                    n_issue     = r_issue + zba_pkg::WCNT_W'(1);
                    n_chk_v     = 1'b1;
                    n_chk_w     = r_issue[zba_pkg::MAP_AW-1:0];
                end
                if (r_chk_v) begin
                    if (w_any) begin
                        n_chk_v    = 1'b0;
                        n_hit_off  = {r_chk_w, w_hit_bit};
                        n_hit_word = w_eff | (zba_pkg::WORD_BITS'(1) << w_hit_bit);
                        n_state    = S_FOUND;
                    end else if (zba_pkg::WCNT_W'(r_chk_w) == r_words - zba_pkg::WCNT_W'(1)) begin
                        n_chk_v     = 1'b0;
                        n_res_valid = 1'b1;
                        n_res.status = zba_pkg::ST_NONE_FREE;
                        n_res.block_number_out = '0;
                        n_state     = S_IDLE;
                    end
                end
            end
            S_FOUND: begin
                n_res_valid = 1'b1;
                n_state     = S_IDLE;
                if (EXT_W'(r_hit_off) >= EXT_W'(i_cfg.zone_count)) begin
                    n_res.status = zba_pkg::ST_BEYOND;
                    n_res.block_number_out = '0;
                end else begin
                    w_ram_we    = 1'b1;
                    w_ram_waddr = zba_pkg::MAP_AW'(r_hit_off >> zba_pkg::BIT_W);
                    w_ram_wdata = r_hit_word;
                    n_valid[zba_pkg::MAP_AW'(r_hit_off >> zba_pkg::BIT_W)] = 1'b1;
                    n_res.status = zba_pkg::ST_OK;
                    n_res.block_number_out = i_cfg.first_data_zone
                                           + zba_pkg::BLK_W'(r_hit_off);
                end
            end
            S_FREE_CHK: begin
                n_res_valid = 1'b1;
                n_state     = S_IDLE;
                n_res.block_number_out = '0;
                if (!w_eff[w_free_bit]) begin
                    n_res.status = zba_pkg::ST_ALREADY_FREE;
                end else begin
                    w_ram_we    = 1'b1;
                    w_ram_waddr = w_free_w;
                    w_ram_wdata = w_eff & ~(zba_pkg::WORD_BITS'(1) << w_free_bit);
                    n_valid[w_free_w] = 1'b1;
                    n_res.status = zba_pkg::ST_OK;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_job      <= n_job;
        r_words    <= n_words;
        r_chk_w    <= n_chk_w;
        r_hit_off  <= n_hit_off;
        r_hit_word <= n_hit_word;
        r_res      <= n_res;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= '0;
            r_chk_v     <= 1'b0;
            r_valid     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_chk_v     <= n_chk_v;
            r_valid     <= n_valid;
            r_res_valid <= n_res_valid;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `ZBA_ASSERT_IMPLY(a_pop_in_idle, o_pop, r_state == S_IDLE, "job taken outside idle")
    `ZBA_ASSERT_IMPLY(a_we_state, w_ram_we, (r_state == S_FOUND) || (r_state == S_FREE_CHK), "map written outside update")
    `ZBA_ASSERT_NEXT(a_found_result, (r_state == S_FOUND) || (r_state == S_FREE_CHK), r_res_valid, "update without result")
    `ZBA_ASSERT_IMPLY(a_err_zero_blk, r_res_valid && (r_res.status != zba_pkg::ST_OK), r_res.block_number_out == '0, "error result carries a block")

endmodule

// ===== hdl/zone_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// zone_bitmap_allocator
// first-fit block allocator over a used-block bitmap of one device
// ----------------------------------------------------------------------------
// A command (allocate, or free of a given block) is taken at a clock edge with
// start high and busy low. Every command gives exactly one result, shown on
// o_res for one cycle with o_res_valid high; the receiver cannot stall it, so
// it must take the transaction in that cycle. Commands go through a two-entry
// queue, so up to two can be taken while the engine works; busy rises only
// when the queue is full. The bitmap lives in a 64-bit-wide ram (one row per
// 64 blocks) and is clear after reset through per-row valid flops, with no
// clearing pass. A free reads its row, then checks and clears the bit and
// registers the result; a free out of range or an allocate with an empty
// scan window registers its result at the pop. An allocate scans from row
// zero, one ram row a cycle; the first clear bit is set if below the zone
// count, else reported beyond; none found gives none free. Configuration
// (first data zone, zone count) must be written by the user through i_cfg_we,
// i_cfg_idx and i_cfg_data only while no command is outstanding; the block does not enforce it.
// ----------------------------------------------------------------------------
module zone_bitmap_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command channel
    input  logic                           start,
    input  zba_pkg::t_cmd_in               i_cmd,
    output logic                           busy,
    // result channel
    output logic                           o_res_valid,
    output zba_pkg::t_result               o_res,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [zba_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // front to queue
    logic             w_push;
    zba_pkg::t_job    w_job_in;
    zba_pkg::t_cfg    w_cfg;

    // queue to back
    zba_pkg::t_job    w_job_out;
    zba_pkg::t_q_stat w_q_stat;
    logic             w_pop;

    // accept, range check and scan sizing
    zba_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_cmd      (i_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_stat   (w_q_stat),
        .o_busy     (busy),
        .o_push     (w_push),
        .o_job      (w_job_in),
        .o_cfg      (w_cfg)
    );

    // classified commands wait here while the engine is busy
    zba_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_stat  (w_q_stat)
    );

    // bitmap scan and update, drives the result strobe
    zba_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_q_stat    (w_q_stat),
        .i_job       (w_job_out),
        .o_pop       (w_pop),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

// ===== sim/zone_bitmap_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// zone_bitmap_allocator_checker
// watches the command, result and register channels of the allocator, keeps
// its own copy of the used-block map and compares every result in order
// ----------------------------------------------------------------------------
module zone_bitmap_allocator_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  zba_pkg::t_cmd_in               i_cmd,
    input  logic                           i_res_valid,
    input  zba_pkg::t_result               i_res,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [zba_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_pending,
    output int                             o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    import zba_pkg::*;

    logic [7:0]       used_bytes [MAP_BYTES];
    logic [BLK_W-1:0] first_zone;
    logic [ZC_W-1:0]  zone_cnt;
    t_result          pending_results [$];
    t_result          want;
    int               mismatch_cnt = 0;

    assign o_errors = mismatch_cnt;

    task automatic report_mismatch(input string what, input t_result got, input t_result exp_r);
        mismatch_cnt++;
        $display("[%0t] %s: got status %0d block %0d, expected status %0d block %0d",
                 $time, what, got.status, got.block_number_out,
                 exp_r.status, exp_r.block_number_out);
    endtask

    // first-fit over whole bytes; window length follows zone count minus first zone
    function automatic t_result alloc_outcome();
        int unsigned fz, zc, nbytes, off;
        t_result     r;
        fz = 32'(first_zone);
        zc = 32'(zone_cnt);
        r = '0;
        r.status = ST_NONE_FREE;
        if (fz > zc) begin
            nbytes = 0;
        end else begin
            nbytes = (zc - fz + 1 + 7) / 8;
            if (nbytes > MAP_BYTES)
                nbytes = MAP_BYTES;
        end
        for (int i = 0; i < nbytes; i++) begin
            if (used_bytes[i] != 8'hFF) begin
                for (int j = 0; j < 8; j++) begin
                    if (!used_bytes[i][j]) begin
                        off = i * 8 + j;
                        if (off >= zc) begin
                            r.status = ST_BEYOND;
                        end else begin
                            used_bytes[i][j] = 1'b1;
                            r.status = ST_OK;
                            r.block_number_out = BLK_W'(fz + off);
                        end
                        return r;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic t_result free_outcome(input logic [BLK_W-1:0] blk);
        int unsigned b, lo, hi, off;
        t_result     r;
        b  = 32'(blk);
        lo = 32'(first_zone);
        hi = lo + 32'(zone_cnt);
        r  = '0;
        if (b < lo || b >= hi || (b - lo) >= MAP_BITS) begin
            r.status = ST_RANGE;
        end else begin
            off = b - lo;
            if (!used_bytes[off / 8][off % 8]) begin
                r.status = ST_ALREADY_FREE;
            end else begin
                used_bytes[off / 8][off % 8] = 1'b0;
                r.status = ST_OK;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (used_bytes[k]) used_bytes[k] = '0;
            first_zone = '0;
            zone_cnt   = ZONE_COUNT_RESET;
            pending_results.delete();
            o_pending <= 0;
        end else begin
            if (i_res_valid) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", i_res, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_res.status !== want.status)
                        report_mismatch("status", i_res, want);
                    if (i_res.block_number_out !== want.block_number_out)
                        report_mismatch("block number", i_res, want);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FIRST_DATA_ZONE)
                    first_zone = i_cfg_data;
                else if (i_cfg_idx == CFG_ZONE_COUNT)
                    zone_cnt = i_cfg_data[ZC_W-1:0];
            end
            if (i_start && !i_busy) begin
                if (i_cmd.cmd == CMD_ALLOC)
                    pending_results.push_back(alloc_outcome());
                else
                    pending_results.push_back(free_outcome(i_cmd.block_number));
            end
            o_pending <= pending_results.size();
        end
    end

endmodule

// ===== sim/zone_bitmap_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// zone_bitmap_allocator_tb
// drives allocate and free commands in bursts over several zone settings;
// a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module zone_bitmap_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import zba_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 125;
    localparam int DRAIN_CYCLES = 80;

    // clock, reset and block ports; the driven ones are known from time zero
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    t_cmd_in               i_cmd      = '0;
    logic                  busy;
    logic                  o_res_valid;
    t_result               o_res;
    logic                  i_cfg_we   = 1'b0;
    logic                  i_cfg_idx  = 1'b0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int pending;
    int mismatches;
    int cycle_cnt = 0;

    // zone window as last written, used only to aim free commands
    int unsigned cur_first_zone;
    int unsigned cur_zone_cnt;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    zone_bitmap_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_cmd       (i_cmd),
        .busy        (busy),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    zone_bitmap_allocator_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_cmd       (i_cmd),
        .i_res_valid (o_res_valid),
        .i_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_errors    (mismatches)
    );

    // watchdog: a hung handshake or a lost result ends here
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("zone_bitmap_allocator: mismatch");
            $finish;
        end
    end

    // present one command and hold it until the block takes it;
    // start stays high afterwards so a burst runs without a bubble
    task automatic issue_cmd(input logic cmd, input logic [BLK_W-1:0] blk);
        t_cmd_in c;
        c.cmd          = cmd;
        c.block_number = blk;
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
    endtask

    // gap between bursts; command bits wander while start is low
    task automatic idle_gap(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_cmd <= t_cmd_in'($urandom);
        end
    endtask

    // lower start and wait for every outstanding transaction to come back
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_FIRST_DATA_ZONE)
            cur_first_zone = 32'(data);
        else
            cur_zone_cnt = 32'(data[ZC_W-1:0]);
    endtask

    task automatic set_zones(input logic [CFG_DATA_W-1:0] fz, input logic [CFG_DATA_W-1:0] zc);
        settle();
        if ($urandom_range(1, 0)) begin
            write_reg(CFG_FIRST_DATA_ZONE, fz);
            write_reg(CFG_ZONE_COUNT, zc);
        end else begin
            write_reg(CFG_ZONE_COUNT, zc);
            write_reg(CFG_FIRST_DATA_ZONE, fz);
        end
    endtask

    // one random command: an allocate at the given percentage, else a free, mostly
    // aimed at the live window, some just below it and some anywhere in the 16-bit space
    task automatic random_cmd(input int alloc_pct);
        int                sel;
        logic [BLK_W-1:0]  blk;
        if ($urandom_range(99, 0) < alloc_pct) begin
            issue_cmd(CMD_ALLOC, BLK_W'($urandom));
        end else begin
            sel = $urandom_range(9, 0);
            if (sel < 7)
                blk = BLK_W'(cur_first_zone + $urandom_range(cur_zone_cnt, 0));
            else if (sel == 7)
                blk = BLK_W'(cur_first_zone - $urandom_range(3, 1));
            else
                blk = BLK_W'($urandom);
            issue_cmd(CMD_FREE, blk);
        end
    endtask

    initial begin
        int                    sent;
        int                    burst;
        int                    alloc_pct;
        logic [CFG_DATA_W-1:0] fz;
        logic [CFG_DATA_W-1:0] zc;

        cur_first_zone = 0;
        cur_zone_cnt   = 32'(ZONE_COUNT_RESET);

        // synchronous reset held low from time zero, then released for good
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part ----
        // full 4096-zone window at block zero
        set_zones(16'd0, 16'd4096);
        issue_cmd(CMD_ALLOC, 16'hFFFF);
        issue_cmd(CMD_ALLOC, 16'h0000);
        issue_cmd(CMD_ALLOC, 16'h5A5A);
        issue_cmd(CMD_FREE, 16'd1);
        issue_cmd(CMD_FREE, 16'd1);          // already free
        issue_cmd(CMD_FREE, 16'hFFFF);       // past the window
        issue_cmd(CMD_FREE, 16'd4095);       // last bit, never set
        issue_cmd(CMD_FREE, 16'd4096);       // one past the window
        issue_cmd(CMD_ALLOC, 16'd0);         // refills the hole at one

        // first zone above the zone count: empty scan window
        set_zones(16'hFFFF, 16'd1);
        issue_cmd(CMD_ALLOC, 16'd0);
        issue_cmd(CMD_FREE, 16'hFFFF);       // maps to bit zero, which is set
        issue_cmd(CMD_FREE, 16'hFFFE);       // below the first zone

        // zero zone count: any clear bit is beyond the limit
        set_zones(16'd0, 16'd0);
        issue_cmd(CMD_ALLOC, 16'd0);
        issue_cmd(CMD_FREE, 16'd0);

        // zone count register takes 13 bits; window longer than the map
        set_zones(16'd0, 16'hFFFF);
        issue_cmd(CMD_FREE, 16'd5000);       // inside window, past the map
        issue_cmd(CMD_FREE, 16'd4096);
        issue_cmd(CMD_ALLOC, 16'd0);

        // one-byte window fills up, then nothing is free
        set_zones(16'd10, 16'd12);
        repeat (6) issue_cmd(CMD_ALLOC, 16'd0);
        issue_cmd(CMD_FREE, 16'd17);
        issue_cmd(CMD_ALLOC, 16'd0);

        // ---- random part ----
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph == 0 ? 4 : $urandom_range(5, 0))
                0, 1: begin
                    fz = CFG_DATA_W'($urandom_range(40, 0));
                    zc = CFG_DATA_W'($urandom_range(96, 1));
                end
                2: begin
                    fz = 16'd0;
                    zc = CFG_DATA_W'($urandom_range(600, 1));
                end
                3: begin
                    fz = CFG_DATA_W'($urandom);
                    zc = CFG_DATA_W'($urandom);
                end
                4: begin
                    fz = 16'd0;
                    zc = 16'd4096;
                end
                default: begin
                    fz = CFG_DATA_W'($urandom_range(16, 0));
                    zc = CFG_DATA_W'($urandom_range(8, 0));
                end
            endcase
            set_zones(fz, zc);

            case ($urandom_range(2, 0))
                0:       alloc_pct = 75;
                1:       alloc_pct = 50;
                default: alloc_pct = 25;
            endcase

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(16, 1);
                repeat (burst) begin
                    random_cmd(alloc_pct);
                    sent++;
                end
                // about a quarter of bursts run straight into the next one
                if ($urandom_range(3, 0) != 0)
                    idle_gap($urandom_range(12, 1));
            end
        end

        // drain and let the engine fall quiet before the verdict
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("zone_bitmap_allocator: match");
        else
            $display("zone_bitmap_allocator: mismatch");
        $finish;
    end

endmodule
